FILE: hdl/device_list_packet_parser_defines.svh
// Assertion macros for the device list packet parser.
// Used by the front and top files; no other dependencies.
`ifndef DEVICE_LIST_PACKET_PARSER_DEFINES_SVH
`define DEVICE_LIST_PACKET_PARSER_DEFINES_SVH
`ifndef SYNTH
`define DLP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DLP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DLP_ASSERT(label, clk, rst_n, prop, msg)
`define DLP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hdl/dlp_pkg.sv
// Types and constants for the device list packet parser.
// No dependencies.
`default_nettype none
package dlp_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  item_kind;
        logic [3:0]  field_id;
        logic [7:0]  item_index;
        logic [63:0] value;
        logic [2:0]  status;
        logic        run_last;
    } t_out_beat;

    localparam logic [2:0] K_HEADER = 3'd0;
    localparam logic [2:0] K_BEGIN  = 3'd1;
    localparam logic [2:0] K_DEVICE = 3'd2;
    localparam logic [2:0] K_FIXED  = 3'd3;
    localparam logic [2:0] K_TEXT   = 3'd4;
    localparam logic [2:0] K_PGN    = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;
    localparam logic [2:0] K_STATUS = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_VER   = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic [7:0] MT_BEGIN  = 8'd1;
    localparam logic [7:0] MT_DEVICE = 8'd2;
    localparam logic [7:0] MT_END    = 8'd3;

    localparam int HDR_LEN   = 8;
    localparam int BEGIN_LEN = 10;
    localparam int DEV_LEN   = 39;
    localparam int END_LEN   = 9;

    // Record decoder phases.
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LENL = 2'd1;
    localparam logic [1:0] PH_LENH = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    // Start byte of each fixed field; entry 13 closes the fixed part.
    function automatic logic [5:0] fixed_start(input logic [3:0] f);
        logic [5:0] s;
        case (f)
            4'd0:  s = 6'd10;
            4'd1:  s = 6'd11;
            4'd2:  s = 6'd13;
            4'd3:  s = 6'd21;
            4'd4:  s = 6'd25;
            4'd5:  s = 6'd29;
            4'd6:  s = 6'd31;
            4'd7:  s = 6'd33;
            4'd8:  s = 6'd34;
            4'd9:  s = 6'd35;
            4'd10: s = 6'd36;
            4'd11: s = 6'd37;
            4'd12: s = 6'd38;
            default: s = 6'd39;
        endcase
        return s;
    endfunction

    // Up to two results per beat travel front to back as one queue entry.
    typedef struct packed {
        logic      two;
        t_out_beat r0;
        t_out_beat r1;
    } t_work;
endpackage
`default_nettype wire

FILE: hdl/dlp_front.sv
// Front part: accepts bytes, tracks packet state, classifies results.
// Depends on dlp_pkg and the defines header.
`default_nettype none
`include "device_list_packet_parser_defines.svh"
module dlp_front import dlp_pkg::*; #(
    parameter int TEXT_KEEP   = 32,
    parameter int PGN_MAX     = 16,
    parameter int PAYLOAD_MAX = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_version,
    input  wire t_in_beat   i_beat,
    input  wire logic       i_fire,
    output t_work           o_work,
    output logic            o_emit
);
    logic [15:0] r_pos,   n_pos;
    logic [7:0]  r_mkind, n_mkind;
    logic [63:0] r_asm,   n_asm;
    logic [7:0]  r_left,  n_left;
    logic [1:0]  r_ph,    n_ph;
    logic [7:0]  r_rtype, n_rtype;
    logic [15:0] r_rleft, n_rleft;
    logic [15:0] r_ridx,  n_ridx;
    logic [7:0]  r_lent,  n_lent;
    logic [2:0]  r_err,   n_err;
    logic [3:0]  r_fld,   n_fld;     // current fixed field
    logic [2:0]  r_foff,  n_foff;    // byte offset within it

    t_out_beat   res;
    logic        has;
    logic [7:0]  b;
    logic [15:0] len;
    logic [2:0]  st;
    logic [15:0] rl_dec;

    always_comb begin
        b = i_beat.data_byte;
        n_pos = r_pos; n_mkind = r_mkind; n_asm = r_asm; n_left = r_left;
        n_ph = r_ph; n_rtype = r_rtype; n_rleft = r_rleft; n_ridx = r_ridx;
        n_lent = r_lent; n_err = r_err; n_fld = r_fld; n_foff = r_foff;
        res = '0; has = 1'b0;
        rl_dec = r_rleft - 16'd1;
        if (r_pos < 16'(PAYLOAD_MAX)) begin
            n_pos = r_pos + 16'd1;
            if (r_pos == 16'd0) begin
                if (b != i_version) n_err = ST_BAD_VER;
            end else if (r_pos == 16'd1) begin
                n_mkind = b;
                if (r_err == ST_OK && (b < MT_BEGIN || b > MT_END)) n_err = ST_BAD_TYPE;
                n_asm = {56'd0, b};
            end else if (r_pos < 16'(HDR_LEN)) begin
                n_asm = r_asm | ({56'd0, b} << {r_pos[2:0] - 3'd1, 3'd0});
                if (r_pos == 16'(HDR_LEN - 1) && r_err == ST_OK) begin
                    has = 1'b1; res.item_kind = K_HEADER; res.value = n_asm;
                end
            end else if (r_err != ST_OK) begin
            end else if (r_mkind == MT_END) begin
                if (r_pos == 16'd8) begin
                    has = 1'b1; res.item_kind = K_END; res.value = {56'd0, b};
                end
            end else if (r_pos == 16'd8) begin
                n_asm = {56'd0, b};
            end else if (r_pos == 16'd9) begin
                n_asm = r_asm | {48'd0, b, 8'd0};
                has = 1'b1;
                res.item_kind = (r_mkind == MT_BEGIN) ? K_BEGIN : K_DEVICE;
                res.value = n_asm;
                n_fld = 4'd0; n_foff = 3'd0;
            end else if (r_mkind != MT_DEVICE) begin
            end else if (r_pos < 16'(DEV_LEN)) begin
                n_asm = (r_foff == 3'd0) ? {56'd0, b}
                                         : (r_asm | ({56'd0, b} << {r_foff, 3'd0}));
                n_foff = r_foff + 3'd1;
                if (r_pos[5:0] + 6'd1 == fixed_start(r_fld + 4'd1)) begin
                    has = 1'b1; res.item_kind = K_FIXED; res.field_id = r_fld;
                    res.value = n_asm;
                    n_fld = r_fld + 4'd1; n_foff = 3'd0;
                    if (r_fld == 4'd12) begin n_left = b; n_ph = PH_TYPE; end
                end
            end else begin
                unique case (r_ph)
                    PH_TYPE: begin
                        if (r_left != 8'd0) begin n_rtype = b; n_ph = PH_LENL; end
                    end
                    PH_LENL: begin n_rleft = {8'd0, b}; n_ph = PH_LENH; end
                    PH_LENH: begin
                        n_rleft = {b, r_rleft[7:0]};
                        n_ridx = '0; n_lent = '0; n_asm = '0;
                        if (n_rleft == 16'd0) begin
                            if (r_left != 8'd0) n_left = r_left - 8'd1;
                            n_ph = PH_TYPE;
                        end else n_ph = PH_DATA;
                    end
                    default: begin
                        if (r_rtype >= 8'd1 && r_rtype <= 8'd7) begin
                            if (r_ridx < 16'(TEXT_KEEP - 1)) begin
                                has = 1'b1; res.item_kind = K_TEXT;
                                res.field_id = r_rtype[3:0]; res.item_index = r_ridx[7:0];
                                res.value = {56'd0, b};
                            end
                        end else if (r_rtype == 8'd8 || r_rtype == 8'd9) begin
                            n_asm = (r_ridx[1:0] == 2'd0) ? {56'd0, b}
                                    : (r_asm | ({56'd0, b} << {r_ridx[1:0], 3'd0}));
                            if (r_ridx[1:0] == 2'd3 && r_lent < 8'(PGN_MAX)) begin
                                has = 1'b1; res.item_kind = K_PGN;
                                res.field_id = r_rtype[3:0]; res.item_index = r_lent;
                                res.value = {32'd0, n_asm[31:0]};
                                n_lent = r_lent + 8'd1;
                            end
                        end
                        n_ridx = r_ridx + 16'd1;
                        n_rleft = rl_dec;
                        if (rl_dec == 16'd0) begin
                            if (r_left != 8'd0) n_left = r_left - 8'd1;
                            n_ph = PH_TYPE;
                        end
                    end
                endcase
            end
        end
        len = n_pos;
        if (len < 16'(HDR_LEN)) st = ST_SHORT;
        else if (n_err != ST_OK) st = n_err;
        else if ((n_mkind == MT_BEGIN && len < 16'(BEGIN_LEN)) ||
                 (n_mkind == MT_DEVICE && len < 16'(DEV_LEN)) ||
                 (n_mkind == MT_END && len < 16'(END_LEN))) st = ST_SHORT;
        else if (n_mkind == MT_DEVICE && n_left != 8'd0) st = ST_TRUNC;
        else st = ST_OK;
        o_work = '0;
        if (i_beat.last_byte) begin
            o_work.two = has;
            o_work.r0 = has ? res : '0;
            if (!has) begin
                o_work.r0.item_kind = K_STATUS; o_work.r0.status = st;
                o_work.r0.run_last = 1'b1;
            end
            o_work.r1.item_kind = K_STATUS; o_work.r1.status = st;
            o_work.r1.run_last = 1'b1;
            n_pos = '0; n_mkind = '0; n_asm = '0; n_left = '0; n_ph = PH_TYPE;
            n_rtype = '0; n_rleft = '0; n_ridx = '0; n_lent = '0; n_err = ST_OK;
        end else begin
            o_work.r0 = res;
            o_work.r0.run_last = 1'b1;
        end
        o_emit = i_fire && (has || i_beat.last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_mkind <= '0; r_asm <= '0; r_left <= '0; r_ph <= PH_TYPE;
            r_rtype <= '0; r_rleft <= '0; r_ridx <= '0; r_lent <= '0; r_err <= ST_OK;
            r_fld <= '0; r_foff <= '0;
        end else if (i_fire) begin
            r_pos <= n_pos; r_mkind <= n_mkind; r_asm <= n_asm; r_left <= n_left;
            r_ph <= n_ph; r_rtype <= n_rtype; r_rleft <= n_rleft; r_ridx <= n_ridx;
            r_lent <= n_lent; r_err <= n_err; r_fld <= n_fld; r_foff <= n_foff;
        end
    end

    `DLP_ASSERT(a_pos_cap, i_clk, i_rst_n, r_pos <= 16'(PAYLOAD_MAX), "position overran cap")
    `DLP_ASSERT(a_fld_range, i_clk, i_rst_n, r_fld <= 4'd13, "fixed field index overran")
    `DLP_ASSERT(a_last_clears, i_clk, i_rst_n,
        (i_fire && i_beat.last_byte) |=> (r_pos == 16'd0 && r_err == ST_OK), "packet not cleared")
endmodule
`default_nettype wire

FILE: hdl/dlp_queue.sv
// Short queue between front and back, entries hold one or two results.
// Depends on dlp_pkg.
`default_nettype none
module dlp_queue import dlp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_work,
    output logic       o_full,
    output logic       o_valid,
    output t_work      o_work,
    input  wire logic  i_pop
);
    t_work      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

FILE: hdl/dlp_back.sv
// Back part: splits queue entries into single result beats on the output.
// Depends on dlp_pkg.
`default_nettype none
module dlp_back import dlp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_work i_work,
    output logic       o_pop,
    output logic       o_valid,
    output t_out_beat  o_data,
    input  wire logic  i_ready
);
    logic r_second;   // first of a pair already sent
    logic take;

    assign o_valid = i_valid;
    assign o_data  = r_second ? i_work.r1 : i_work.r0;
    assign take    = i_valid && i_ready;
    assign o_pop   = take && (r_second || !i_work.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_second <= 1'b0;
        else if (take) r_second <= !r_second && i_work.two;
    end
endmodule
`default_nettype wire

FILE: hdl/device_list_packet_parser.sv
// Top level of the device list packet parser.
// Depends on dlp_pkg, dlp_front, dlp_queue, dlp_back and the defines header.
//
//  channel | signals                         | beat
//  --------+---------------------------------+-------------------------------
//  in      | i_in_valid / o_in_ready         | one payload byte + last mark
//  out     | o_out_valid / i_out_ready       | one result item
//  cfg     | i_cfg_we / i_cfg_wdata          | expected version, no wait
//
// One input byte per cycle while the queue has room; the front decodes it in the accepting cycle.
// A byte yields up to two results (a decoded item plus the closing status);
// those leave as two separate output beats, so a stream of such bytes runs at the output's pace.
// A two-entry queue decouples front and back; the input stalls only when full.
// Synchronous active-low reset clears packet state; version resets to 1.
`default_nettype none
`include "device_list_packet_parser_defines.svh"
module device_list_packet_parser import dlp_pkg::*; #(
    parameter int TEXT_KEEP   = 32,
    parameter int PGN_MAX     = 16,
    parameter int PAYLOAD_MAX = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_beat   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_beat       o_out_data
);
    logic [7:0] r_version;
    logic       fire, emit, q_full, q_valid, pop;
    t_work      work, q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_version <= 8'd1;
        else if (i_cfg_we) r_version <= i_cfg_wdata;
    end

    assign o_in_ready = !q_full;
    assign fire       = i_in_valid && o_in_ready;

    dlp_front #(.TEXT_KEEP(TEXT_KEEP), .PGN_MAX(PGN_MAX), .PAYLOAD_MAX(PAYLOAD_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_version(r_version),
        .i_beat(i_in_data), .i_fire(fire), .o_work(work), .o_emit(emit)
    );

    dlp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(emit), .i_work(work),
        .o_full(q_full), .o_valid(q_valid), .o_work(q_work), .i_pop(pop)
    );

    dlp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_work(q_work),
        .o_pop(pop), .o_valid(o_out_valid), .o_data(o_out_data), .i_ready(i_out_ready)
    );

    `DLP_ASSERT(a_no_push_full, i_clk, i_rst_n, !(emit && q_full), "push into full queue")
    `DLP_ASSERT(a_pop_valid, i_clk, i_rst_n, pop |-> o_out_valid, "pop without valid")
    `DLP_ASSERT(a_reset_version, i_clk, i_rst_n, $rose(i_rst_n) |-> r_version == 8'd1, "version not reset")
endmodule
`default_nettype wire

FILE: tb/sv/dlp_checker.sv
// Scoreboard for the device list packet parser: watches both channels,
// predicts results per accepted input beat and compares in order. Uses dlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlp_checker import dlp_pkg::*; #(
    parameter int TEXT_KEEP   = 32,
    parameter int PGN_MAX     = 16,
    parameter int PAYLOAD_MAX = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_beat  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_beat i_out_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_results
);
    t_out_beat   expected_q[$];
    logic [7:0]  version;
    logic [15:0] pos;
    logic [7:0]  mkind;
    logic [63:0] acc;
    logic [7:0]  left_fields;
    logic [1:0]  phase;
    logic [7:0]  rtype;
    logic [15:0] rleft;
    logic [15:0] ridx;
    logic [7:0]  nlist;
    logic [2:0]  err;
    t_out_beat   step_out[2];
    int          nstep;

    assign o_pending = expected_q.size();

    function automatic logic [5:0] field_start(input int f);
        case (f)
            0: return 6'd10; 1: return 6'd11; 2: return 6'd13; 3: return 6'd21;
            4: return 6'd25; 5: return 6'd29; 6: return 6'd31; 7: return 6'd33;
            8: return 6'd34; 9: return 6'd35; 10: return 6'd36; 11: return 6'd37;
            12: return 6'd38; default: return 6'd39;
        endcase
    endfunction

    task automatic emit(input logic [2:0] k, input logic [3:0] fid, input logic [7:0] idx,
                        input logic [63:0] val, input logic [2:0] st);
        if (nstep < 2) begin
            step_out[nstep] = '{k, fid, idx, val, st, 1'b0};
            nstep++;
        end
    endtask

    task automatic clear_packet();
        pos = 0; mkind = 0; acc = 0; left_fields = 0; phase = PH_TYPE;
        rtype = 0; rleft = 0; ridx = 0; nlist = 0; err = ST_OK;
    endtask

    task automatic record_byte(input logic [7:0] b);
        if (phase == PH_TYPE) begin
            if (left_fields == 0) return;
            rtype = b; phase = PH_LENL;
        end else if (phase == PH_LENL) begin
            rleft = b; phase = PH_LENH;
        end else if (phase == PH_LENH) begin
            rleft = rleft | (16'(b) << 8);
            ridx = 0; nlist = 0; acc = 0;
            if (rleft == 0) begin
                if (left_fields > 0) left_fields--;
                phase = PH_TYPE;
            end else phase = PH_DATA;
        end else begin
            if (rtype >= 1 && rtype <= 7) begin
                if (ridx < TEXT_KEEP - 1) emit(K_TEXT, rtype[3:0], ridx[7:0], 64'(b), ST_OK);
            end else if (rtype == 8 || rtype == 9) begin
                if (ridx[1:0] == 0) acc = 64'(b);
                else acc |= 64'(b) << (8 * ridx[1:0]);
                if (ridx[1:0] == 3 && nlist < PGN_MAX) begin
                    emit(K_PGN, rtype[3:0], nlist, acc & 64'hFFFF_FFFF, ST_OK);
                    nlist++;
                end
            end
            ridx++;
            rleft--;
            if (rleft == 0) begin
                if (left_fields > 0) left_fields--;
                phase = PH_TYPE;
            end
        end
    endtask

    task automatic decode_byte(input int p, input logic [7:0] b);
        int f;
        int off;
        if (p == 0) begin
            if (b != version) err = ST_BAD_VER;
            return;
        end
        if (p == 1) begin
            mkind = b;
            if (err == ST_OK && (b < 1 || b > 3)) err = ST_BAD_TYPE;
            acc = 64'(b);
            return;
        end
        if (p < HDR_LEN) begin
            acc |= 64'(b) << (8 * (p - 1));
            if (p == HDR_LEN - 1 && err == ST_OK) emit(K_HEADER, 0, 0, acc, ST_OK);
            return;
        end
        if (err != ST_OK) return;
        if (mkind == MT_END) begin
            if (p == 8) emit(K_END, 0, 0, 64'(b), ST_OK);
            return;
        end
        if (p == 8) begin acc = 64'(b); return; end
        if (p == 9) begin
            acc |= 64'(b) << 8;
            emit(mkind == MT_BEGIN ? K_BEGIN : K_DEVICE, 0, 0, acc, ST_OK);
            return;
        end
        if (mkind != MT_DEVICE) return;
        if (p < DEV_LEN) begin
            f = 0;
            while (f < 12 && field_start(f + 1) <= p) f++;
            off = p - field_start(f);
            if (off == 0) acc = 64'(b);
            else acc |= 64'(b) << (8 * (off & 7));
            if (p + 1 == field_start(f + 1)) begin
                emit(K_FIXED, f[3:0], 0, acc, ST_OK);
                if (f == 12) begin left_fields = b; phase = PH_TYPE; end
            end
            return;
        end
        record_byte(b);
    endtask

    // Predict all results caused by one accepted input beat.
    task automatic predict_beat(input t_in_beat beat);
        int len;
        logic [2:0] st;
        nstep = 0;
        if (pos < PAYLOAD_MAX) begin
            decode_byte(pos, beat.data_byte);
            pos++;
        end
        if (beat.last_byte) begin
            len = pos;
            st = ST_OK;
            if (len < HDR_LEN) st = ST_SHORT;
            else if (err != ST_OK) st = err;
            else if ((mkind == MT_BEGIN && len < BEGIN_LEN) ||
                     (mkind == MT_DEVICE && len < DEV_LEN) ||
                     (mkind == MT_END && len < END_LEN)) st = ST_SHORT;
            else if (mkind == MT_DEVICE && left_fields != 0) st = ST_TRUNC;
            emit(K_STATUS, 0, 0, 0, st);
            clear_packet();
        end
        if (nstep > 0) step_out[nstep - 1].run_last = 1'b1;
        for (int i = 0; i < nstep; i++) expected_q.push_back(step_out[i]);
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_b;
        if (!i_rst_n) begin
            version = 8'd1;
            clear_packet();
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result beat %p", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_b = expected_q.pop_front();
                    if (exp_b !== i_out_data) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %p, got %p", exp_b, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
            if (i_cfg_we) version = i_cfg_wdata;
        end
    end
endmodule
`default_nettype wire

FILE: tb/sv/tb_device_list_packet_parser.sv
// Testbench top for the device list packet parser: packet stimulus, random
// idling, version register sweeps and the verdict. Needs dlp_pkg, dlp_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_device_list_packet_parser;
    import dlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_beat   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_beat  out_data;
    int         errors;
    int         pending;
    int         results;
    int         beats_sent = 0;
    int         packets_sent = 0;
    int         idle_cycles = 0;
    logic [7:0] cur_version = 8'd1;
    logic [7:0] pkt[$];

    always #10 clk = ~clk;

    device_list_packet_parser u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    dlp_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Watchdog: cycles with no beat moving on either channel.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: per result draw a random stall; at least a quarter of the draws give none.
    initial begin : sink
        int gap;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            repeat (gap) @(posedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            out_ready <= 1'b0;
        end
    end

    // Send one beat after a random gap; stretches of no-gap bursts come from the per-packet burst flag.
    task automatic send_beat(input logic [7:0] b, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{b, last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_packet();
        bit burst;
        burst = ($urandom_range(0, 2) == 0);
        foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1, burst);
        in_valid <= 1'b0;
        packets_sent++;
    endtask

    task automatic put16(input int v);
        pkt.push_back(v[7:0]);
        pkt.push_back(v[15:8]);
    endtask

    task automatic make_header(input logic [7:0] ver, input logic [7:0] mt);
        pkt.delete();
        pkt.push_back(ver);
        pkt.push_back(mt);
        repeat (6) pkt.push_back(8'($urandom));
    endtask

    // Device record: header, index/total, 29 fixed bytes, value fields.
    task automatic make_device(input logic [7:0] nfields, input int max_len, input bit cut);
        int ftype;
        int flen;
        make_header(cur_version, MT_DEVICE);
        repeat (2) pkt.push_back(8'($urandom));
        repeat (28) pkt.push_back(8'($urandom));
        pkt.push_back(nfields);
        for (int f = 0; f < nfields; f++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: ftype = $urandom_range(1, 7);
                3, 4: ftype = 8;
                5, 6: ftype = 9;
                7: ftype = 0;
                default: ftype = $urandom_range(10, 255);
            endcase
            flen = $urandom_range(0, max_len);
            pkt.push_back(ftype[7:0]);
            put16(flen);
            repeat (flen) pkt.push_back(8'($urandom));
        end
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
        if (cut && pkt.size() > 1) pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];
    endtask

    task automatic make_random_packet();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 9) make_device($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 80 : 12,
                                 $urandom_range(0, 7) == 0);
        else if (sel < 12) begin
            make_header(cur_version, MT_BEGIN);
            repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
        end else if (sel < 15) begin
            make_header(cur_version, MT_END);
            repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
        end else if (sel < 17) begin
            make_header(8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 40)) pkt.push_back(8'($urandom));
        end else begin
            pkt.delete();
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
        end
    endtask

    // Version writes only when idle: all results in, then the block's latency.
    task automatic write_version(input logic [7:0] v);
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_version = v;
    endtask

    initial begin : stim
        logic [7:0] versions[4];
        versions = '{8'd1, 8'd0, 8'd255, 8'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each message type, short and bad packets, truncation cases.
        make_header(cur_version, MT_BEGIN); put16(16'hFFFF); send_packet();
        make_header(cur_version, MT_END); pkt.push_back(8'hFF); send_packet();
        make_header(cur_version, MT_END); send_packet();
        make_header(cur_version, MT_BEGIN); pkt.push_back(8'h00); send_packet();
        make_header(8'hFF, MT_BEGIN); put16(1); send_packet();
        make_header(cur_version, 8'd0); put16(0); send_packet();
        make_header(cur_version, 8'd255); send_packet();
        pkt.delete(); repeat (5) pkt.push_back(8'hFF); send_packet();
        pkt = '{8'h00}; send_packet();
        make_device(0, 0, 0); send_packet();
        make_device(3, 6, 0); pkt.pop_back(); pkt.push_back(8'h00); send_packet();
        make_device(0, 0, 0); pkt.pop_back(); send_packet();
        // Long text field and a pgn list past the cap with a partial tail.
        make_device(2, 0, 0);
        pkt = pkt[0:38];
        pkt.push_back(8'd1); put16(40); repeat (40) pkt.push_back(8'($urandom));
        pkt.push_back(8'd8); put16(70); repeat (70) pkt.push_back(8'($urandom));
        send_packet();
        // Device with fields left open: truncated status.
        make_device(0, 0, 0); pkt[38] = 8'd5; pkt.push_back(8'd9); put16(8); send_packet();
        // Overlong packet past the payload limit.
        make_device(0, 0, 0);
        pkt[38] = 8'd1;
        pkt.push_back(8'd9); put16(2000); repeat (1030) pkt.push_back(8'($urandom));
        send_packet();

        // Random phases, each with its own version setting.
        for (int ph = 0; ph < 4; ph++) begin
            write_version(versions[ph] == 8'd0 && ph == 3 ? 8'($urandom) : versions[ph]);
            while (beats_sent < 1500 + 65 * (ph + 1)) begin
                make_random_packet();
                send_packet();
            end
        end

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d packets, %0d input beats, %0d result beats checked",
                 packets_sent, beats_sent, results);
        $display("version register swept over 1, 0, 255 and a random value");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/dlp_pkg.sv
hdl/dlp_front.sv
hdl/dlp_queue.sv
hdl/dlp_back.sv
hdl/device_list_packet_parser.sv
tb/sv/dlp_checker.sv
tb/sv/tb_device_list_packet_parser.sv
